// ===== rtl/bracket_balance_checker_assert.svh =====
// assertion macros for the checker file
// used by bbc_checker; no other dependencies
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH

// checked only outside reset
`define BBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bbc_pkg.sv =====
// types, codes and bracket decode for the bracket balance checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    typedef logic [1:0] kind_t;
    typedef logic [2:0] status_t;

    localparam kind_t KIND_ROUND  = 2'd0;
    localparam kind_t KIND_SQUARE = 2'd1;
    localparam kind_t KIND_CURLY  = 2'd2;
    localparam kind_t KIND_NONE   = 2'd3;

    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_BALANCED   = 3'd1;
    localparam status_t ST_UNBALANCED = 3'd2;
    localparam status_t ST_MISMATCH   = 3'd3;
    localparam status_t ST_EMPTY_CLOSE = 3'd4;
    localparam status_t ST_OVERFLOW   = 3'd5;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    typedef struct packed {
        status_t    status;
        logic [7:0] depth;
        logic       eos;
    } result_t;

    function automatic kind_t open_kind(input logic [7:0] c);
        case (c)
            CH_OPEN_ROUND:  open_kind = KIND_ROUND;
            CH_OPEN_SQUARE: open_kind = KIND_SQUARE;
            CH_OPEN_CURLY:  open_kind = KIND_CURLY;
            default:        open_kind = KIND_NONE;
        endcase
    endfunction

    function automatic kind_t close_kind(input logic [7:0] c);
        case (c)
            CH_CLOSE_ROUND:  close_kind = KIND_ROUND;
            CH_CLOSE_SQUARE: close_kind = KIND_SQUARE;
            CH_CLOSE_CURLY:  close_kind = KIND_CURLY;
            default:         close_kind = KIND_NONE;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bbc_stack.sv =====
// bracket stack: entry memory, top-of-stack register, count and sticky error
// uses bbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bbc_stack #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      ch,
    input  wire logic            last_char,
    output bbc_pkg::result_t     res
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_FULL = CW'(STACK_DEPTH);

    bbc_pkg::kind_t   mem [STACK_DEPTH];

    logic [CW-1:0]    count_reg, count_next, count_after;
    bbc_pkg::status_t err_reg, err_next, err_after;
    bbc_pkg::kind_t   top_reg, top_next;
    bbc_pkg::kind_t   below_reg;
    bbc_pkg::kind_t   ok, ck;
    logic             push, pop;
    logic [CW-1:0]    rd_addr;

    always_comb
    begin
        ok          = bbc_pkg::open_kind(ch);
        ck          = bbc_pkg::close_kind(ch);
        push        = 1'b0;
        pop         = 1'b0;
        err_after   = err_reg;
        count_after = count_reg;
        if (err_reg == bbc_pkg::ST_OK)
        begin
            if (ok != bbc_pkg::KIND_NONE)
            begin
                if (count_reg == DEPTH_FULL)
                    err_after = bbc_pkg::ST_OVERFLOW;
                else
                begin
                    push        = 1'b1;
                    count_after = count_reg + CW'(1);
                end
            end
            else if (ck != bbc_pkg::KIND_NONE)
            begin
                if (count_reg == '0)
                    err_after = bbc_pkg::ST_EMPTY_CLOSE;
                else if (top_reg != ck)
                    err_after = bbc_pkg::ST_MISMATCH;
                else
                begin
                    pop         = 1'b1;
                    count_after = count_reg - CW'(1);
                end
            end
        end

        // verdict on the last character
        if (last_char && err_after == bbc_pkg::ST_OK)
            res.status = (count_after == '0) ? bbc_pkg::ST_BALANCED
                                             : bbc_pkg::ST_UNBALANCED;
        else
            res.status = err_after;
        res.depth = 8'(count_after);
        res.eos   = last_char;

        count_next = count_reg;
        err_next   = err_reg;
        top_next   = top_reg;
        if (accept)
        begin
            count_next = last_char ? '0 : count_after;
            err_next   = last_char ? bbc_pkg::ST_OK : err_after;
            if (push)
                top_next = ok;
            else if (pop)
                top_next = below_reg;
        end
        rd_addr = count_next - CW'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= bbc_pkg::ST_OK;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // every accepted push lands in memory; the entry below the top is read ahead
    // so a pop finds it already in below_reg
    always_ff @(posedge clk)
    begin
        if (accept && push)
            mem[count_reg[AW-1:0]] <= ok;
        if (count_next >= CW'(2))
            below_reg <= mem[rd_addr[AW-1:0]];
    end

endmodule

`default_nettype wire

// ===== rtl/bbc_outbuf.sv =====
// two-word output buffer between the stack logic and the result port
// uses bbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bbc_outbuf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire bbc_pkg::result_t wr_data,
    output logic                  has_room,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output bbc_pkg::result_t      rd_data
);

    bbc_pkg::result_t buf_q [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       rd;

    always_comb
    begin
        has_room    = (fill_reg != 2'd2);
        rd_valid    = (fill_reg != 2'd0);
        rd_data     = buf_q[rd_ptr_reg];
        rd          = rd_valid && rd_ready;
        wr_ptr_next = wr_ptr_reg ^ wr;
        rd_ptr_next = rd_ptr_reg ^ rd;
        fill_next   = fill_reg + 2'(wr) - 2'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            buf_q[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== rtl/bracket_balance_checker.sv =====
// bracket balance checker top level: stack logic plus output buffer
// uses bbc_pkg, bbc_stack, bbc_outbuf
`timescale 1ns / 1ps
`default_nettype none

// Checks round, square and curly brackets in a byte stream, one character
// per word, and returns exactly one result word per character. Opening
// brackets push their kind onto a stack of STACK_DEPTH entries held in a
// single-port-write memory; the top entry sits in a register and the entry
// below it is read ahead, so a push or a pop never waits on the memory.
// The block sustains one character per clock while in_ready is high;
// each result is registered in the two-word output buffer as its
// character is accepted, so input keeps flowing while a result waits to be
// taken (in_ready drops only when both buffer words are occupied). The first
// error (mismatch, close on empty, overflow) is sticky: later characters
// report it with the frozen depth until the character flagged last_char,
// which reports the verdict, or the error if there is one, and clears stack
// and error. nesting_depth is the low 8 bits of the stack count. No clearing
// pass is needed after reset: only entries below the stack count are ever read.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic       last_char,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      status,
    output logic [7:0]      nesting_depth,
    output logic            end_of_string
);

    logic             accept;
    bbc_pkg::result_t res;
    bbc_pkg::result_t out_word;

    // a word is taken whenever one is offered and the buffer has a free slot
    assign accept = in_valid && in_ready;

    bbc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (ch),
        .last_char (last_char),
        .res       (res)
    );

    bbc_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (accept),
        .wr_data  (res),
        .has_room (in_ready),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (out_word)
    );

    assign status        = out_word.status;
    assign nesting_depth = out_word.depth;
    assign end_of_string = out_word.eos;

endmodule

`default_nettype wire

// ===== rtl/bbc_checker.sv =====
// port-level checks for the bracket balance checker, bound to the top level
// uses bbc_pkg and bracket_balance_checker_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "bracket_balance_checker_assert.svh"

module bbc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] ch,
    input wire logic       last_char,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] status,
    input wire logic [7:0] nesting_depth,
    input wire logic       end_of_string
);

    logic is_verdict;
    logic is_empty_code;
    logic out_stable;

    assign is_verdict    = (status == bbc_pkg::ST_BALANCED) ||
                           (status == bbc_pkg::ST_UNBALANCED);
    assign is_empty_code = (status == bbc_pkg::ST_BALANCED) ||
                           (status == bbc_pkg::ST_EMPTY_CLOSE);
    assign out_stable    = 1'b1;

    // a waiting input word holds
    `BBC_ASSERT(a_in_hold, (in_valid && !in_ready) |=> (in_valid && $stable(ch) && $stable(last_char)), "input changed while waiting")

    // a verdict only closes a string
    `BBC_ASSERT(a_verdict_at_end, (out_valid && !end_of_string) |-> !is_verdict, "verdict before end of string")

    // balanced means nothing left open; close on empty means nothing was open
    `BBC_ASSERT(a_empty_depth, (out_valid && is_empty_code) |-> (nesting_depth == 8'd0), "depth not zero")

    // a stalled result word holds
    `BBC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable({status, nesting_depth, end_of_string})), "result changed while stalled")

    // nothing comes out right after a reset edge
    `BBC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);

`default_nettype wire
